FILE: rtl/cbd_pkg.sv
// Package: shared types, constants and helpers for the chunked body decoder.
`timescale 1ns / 1ps
package cbd_pkg;

  // Default width of the chunk size and byte counter
  localparam int SIZE_BITS_DEF = 32;

  // Control characters
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_HT = 8'h09;

  // Hex digit radix shift (one nibble)
  localparam int NIBBLE_BITS = 4;

  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_DATA  = 3'd1,
    PH_CR    = 3'd2,
    PH_LF    = 3'd3,
    PH_DONE  = 3'd4,
    PH_ERROR = 3'd5
  } phase_t;

  // One input byte as held in the input register
  typedef struct packed {
    logic [7:0] in_byte;
    logic       body_start;
  } item_t;

  // One decoded result
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       chunk_last_byte;
    logic       body_done;
    logic       framing_error;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decode one ASCII hex digit
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.val = 4'(c - 8'h30);
    end else if (c inside {[8'h61:8'h66]}) begin
      h.val = 4'(c - 8'h57);
    end else if (c inside {[8'h41:8'h46]}) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok  = 1'b0;
    end
    return h;
  endfunction

endpackage

FILE: rtl/chunked_body_decoder_top.sv
// Top level of the chunked body decoder.
//
//   channel | direction | handshake           | fields
//   --------+-----------+---------------------+-------------------------------------
//   in      | input     | in_valid / in_stall | in_byte, in_body_start
//   out     | output    | out_valid/out_stall | out_payload_byte, out_payload_valid,
//           |           |                     | out_chunk_last_byte, out_body_done,
//           |           |                     | out_framing_error
//
// One byte per clock while out_stall is low, via the input and result registers.
// The size-line accumulator and byte counter update in a single pass per byte.
// Synchronous active-low reset returns the decoder to the start of a size line.
// A stall on the result side holds the result and, once the input register is
// full, stalls the input side in the same cycle.
`timescale 1ns / 1ps
module chunked_body_decoder_top
  import cbd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_body_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_payload_valid,
  output logic       out_chunk_last_byte,
  output logic       out_body_done,
  output logic       out_framing_error
);

  logic    item_valid;
  item_t   item;
  logic    out_ready;
  logic    advance;
  result_t res;

  // Move the held byte into the result register
  assign advance = item_valid && out_ready;

  cbd_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_body_start (in_body_start),
    .down_ready    (out_ready),
    .item_valid    (item_valid),
    .item          (item)
  );

  cbd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .res     (res)
  );

  cbd_out_stage u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (advance),
    .res                 (res),
    .ready               (out_ready),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_payload_byte    (out_payload_byte),
    .out_payload_valid   (out_payload_valid),
    .out_chunk_last_byte (out_chunk_last_byte),
    .out_body_done       (out_body_done),
    .out_framing_error   (out_framing_error)
  );

endmodule

FILE: rtl/cbd_in_stage.sv
// Input register: holds one accepted byte until the decoder takes it.
`timescale 1ns / 1ps
module cbd_in_stage
  import cbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_body_start,
  input  logic       down_ready,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;

  // Accept when empty or when the held item moves on in this cycle
  assign in_stall   = valid_r && !down_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Hold the occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  // Load the byte on transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.in_byte    <= in_byte;
      item_r.body_start <= in_body_start;
    end
  end

endmodule

FILE: rtl/cbd_core.sv
// Decoder core: framing state and the single-pass decode of one byte.
`timescale 1ns / 1ps
module cbd_core
  import cbd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    advance,
  input  item_t   item,
  output result_t res
);

  phase_t               phase_r, phase_nxt, cur_phase;
  logic [SIZE_BITS-1:0] size_r, size_nxt, cur_size;
  logic [SIZE_BITS-1:0] count_r, count_nxt, cur_count, count_inc;
  logic                 open_r, open_nxt, cur_open;
  logic                 begun_r, begun_nxt, cur_begun;
  logic                 cr_r, cr_nxt, cur_cr;
  logic [7:0]           b;
  hex_t                 hx;
  logic                 size_sat;

  assign b  = item.in_byte;
  assign hx = hex_decode(b);

  // Start of body: clear state before decoding this byte
  always_comb begin
    if (item.body_start) begin
      cur_phase = PH_SIZE;
      cur_size  = '0;
      cur_count = '0;
      cur_open  = 1'b1;
      cur_begun = 1'b0;
      cur_cr    = 1'b0;
    end else begin
      cur_phase = phase_r;
      cur_size  = size_r;
      cur_count = count_r;
      cur_open  = open_r;
      cur_begun = begun_r;
      cur_cr    = cr_r;
    end
  end

  // Another nibble would overflow: saturate
  assign size_sat  = |cur_size[SIZE_BITS-1 -: NIBBLE_BITS];
  assign count_inc = cur_count + SIZE_BITS'(1);

  // Next state and result
  always_comb begin
    phase_nxt           = cur_phase;
    size_nxt            = cur_size;
    count_nxt           = cur_count;
    open_nxt            = cur_open;
    begun_nxt           = cur_begun;
    cr_nxt              = cur_cr;
    res.payload_byte    = 8'd0;
    res.payload_valid   = 1'b0;
    res.chunk_last_byte = 1'b0;
    case (cur_phase)
      PH_SIZE: begin
        if (cur_cr && b == CH_LF) begin
          cr_nxt    = 1'b0;
          count_nxt = '0;
          phase_nxt = (cur_size == '0) ? PH_DONE : PH_DATA;
        end else begin
          cr_nxt = (b == CH_CR);
          if (cur_open) begin
            if (hx.ok) begin
              begun_nxt = 1'b1;
              size_nxt  = size_sat ? '1
                        : {cur_size[SIZE_BITS-NIBBLE_BITS-1:0], hx.val};
            end else if (!cur_begun && (b == CH_SP || b == CH_HT)) begin
              // skip leading blank
            end else begin
              open_nxt = 1'b0;
            end
          end
        end
      end
      PH_DATA: begin
        res.payload_byte  = b;
        res.payload_valid = 1'b1;
        count_nxt         = count_inc;
        if (count_inc >= cur_size) begin
          res.chunk_last_byte = 1'b1;
          phase_nxt           = PH_CR;
        end
      end
      PH_CR: begin
        phase_nxt = (b == CH_CR) ? PH_LF : PH_ERROR;
      end
      PH_LF: begin
        if (b == CH_LF) begin
          phase_nxt = PH_SIZE;
          size_nxt  = '0;
          count_nxt = '0;
          open_nxt  = 1'b1;
          begun_nxt = 1'b0;
          cr_nxt    = 1'b0;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_nxt = PH_ERROR;
      end
    endcase
    res.body_done     = (phase_nxt == PH_DONE);
    res.framing_error = (phase_nxt == PH_ERROR);
  end

  // Advance state when the byte moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      size_r  <= '0;
      count_r <= '0;
      open_r  <= 1'b1;
      begun_r <= 1'b0;
      cr_r    <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      size_r  <= size_nxt;
      count_r <= count_nxt;
      open_r  <= open_nxt;
      begun_r <= begun_nxt;
      cr_r    <= cr_nxt;
    end
  end

endmodule

FILE: rtl/cbd_out_stage.sv
// Result register: holds one decoded result until the receiver takes it.
`timescale 1ns / 1ps
module cbd_out_stage
  import cbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  result_t    res,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_payload_valid,
  output logic       out_chunk_last_byte,
  output logic       out_body_done,
  output logic       out_framing_error
);

  logic    valid_r;
  result_t res_r;

  // Free when empty or when the held result transfers now
  assign ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid           = valid_r;
  assign out_payload_byte    = res_r.payload_byte;
  assign out_payload_valid   = res_r.payload_valid;
  assign out_chunk_last_byte = res_r.chunk_last_byte;
  assign out_body_done       = res_r.body_done;
  assign out_framing_error   = res_r.framing_error;

endmodule

FILE: rtl/cbd_checker.sv
// Port-level checker for the chunked body decoder, bound to the top level.
`timescale 1ns / 1ps
module cbd_port_checks (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_payload_byte,
  input logic       out_payload_valid,
  input logic       out_chunk_last_byte,
  input logic       out_body_done,
  input logic       out_framing_error
);

  // No result is offered right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_payload_valid) && $stable(out_chunk_last_byte)
      && $stable(out_body_done) && $stable(out_framing_error))
    else $error("stalled result changed");

  // Non-payload results carry zero byte and no last flag
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_byte == 8'd0
      && !out_chunk_last_byte)
    else $error("payload fields set on non-payload transfer");

  // Payload never coincides with done or error
  a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> !out_body_done && !out_framing_error)
    else $error("payload with done or error");

  // Done and error are exclusive
  a_done_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_body_done && out_framing_error))
    else $error("done and error together");

endmodule

bind chunked_body_decoder_top cbd_port_checks u_cbd_checker (.*);
